[rtl/fips_pkg.sv]
// Shared types and constants for the first interaction point select block.
// Used by the front accumulator, the hit queue, the divider back end and the top level.
package fips_pkg;

    localparam int MAX_POINTS = 16;
    localparam int SEEN_W     = $clog2(MAX_POINTS + 1);
    localparam int SUM_W      = 42;
    localparam int WSUM_W     = 25;
    localparam int Q_DEPTH    = 2;

    localparam logic [2:0] MODE_MIN_Z   = 3'd0;
    localparam logic [2:0] MODE_MEAN    = 3'd1;
    localparam logic [2:0] MODE_WEIGHT  = 3'd2;
    localparam logic [2:0] MODE_CENTRE  = 3'd3;
    localparam logic [2:0] MODE_MAX_E   = 3'd4;
    localparam logic [2:0] MODE_HYBRID  = 3'd5;

    localparam logic [1:0] REG_SELECT_MODE = 2'd0;
    localparam logic [1:0] REG_PAD_POLICY  = 2'd1;
    localparam logic [1:0] REG_ACCEPT_FIX  = 2'd2;
    localparam logic [1:0] REG_HYBRID_THR  = 2'd3;

    localparam logic [1:0] PAD_STRICT = 2'd0;
    localparam logic [1:0] PAD_EITHER = 2'd1;
    localparam logic [1:0] PAD_NOISY  = 2'd2;

    localparam logic [7:0] PAD_OK    = 8'd0;
    localparam logic [7:0] PAD_RETRY = 8'd128;

    // finished hit handed from front to back
    typedef struct packed {
        logic                    divide;   // 1: quotient of sums, 0: take best point
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] sz;
        logic [WSUM_W-1:0]       den;      // zero gives the origin
        logic signed [15:0]      bx;
        logic signed [15:0]      by;
        logic signed [15:0]      bz;
        logic                    valid;
        logic                    fix;
    } hit_t;

endpackage

[rtl/first_interaction_point_select_top.sv]
// First interaction point select, top level. Points are taken one beat per cycle
// unless a finished hit waits in the front for room in the hit queue. Mean modes with
// a nonzero divisor run three serial divides, one per axis; best-point modes skip them.
// A two-entry hit queue lets the front keep accepting points during a divide.
// Synchronous active-low reset restores register defaults and clears all hit state.
module first_interaction_point_select_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [19:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_x, point_y, point_z, point_energy, hit_energy, pad_code, point_count
    input  logic [103:0] s_tdata,
    // noisy_crystal, t0_is_nan
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // first_x, first_y, first_z
    output logic [47:0]  m_tdata,
    // hit_valid, fix_applied
    output logic [1:0]   m_tuser
);
    logic           fv, fr, bv, br;
    fips_pkg::hit_t fh, bh;
    logic           ok, fx;

    fips_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .px(s_tdata[15:0]), .py(s_tdata[31:16]), .pz(s_tdata[47:32]),
        .pe(s_tdata[68:48]), .hit_e(s_tdata[88:69]), .pad(s_tdata[96:89]),
        .noisy(s_tuser[0]), .t0nan(s_tuser[1]), .count(s_tdata[101:97]),
        .last(s_tlast),
        .hit_valid(fv), .hit_ready(fr), .hit(fh)
    );

    fips_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(fv), .wr_ready(fr), .wr_data(fh),
        .rd_valid(bv), .rd_ready(br), .rd_data(bh)
    );

    fips_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(bv), .q_ready(br), .q_data(bh),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_xyz(m_tdata),
        .m_ok(ok), .m_fix(fx)
    );

    assign m_tuser = {fx, ok};
endmodule

[rtl/fips_front.sv]
// Front end: accepts point beats, applies the fix rule and accumulates one hit.
// Depends on fips_pkg; emits one hit_t per last beat.
module fips_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [19:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   px,
    input  logic signed [15:0]   py,
    input  logic signed [15:0]   pz,
    input  logic signed [20:0]   pe,
    input  logic [19:0]          hit_e,
    input  logic [7:0]           pad,
    input  logic                 noisy,
    input  logic                 t0nan,
    input  logic [4:0]           count,
    input  logic                 last,
    output logic                 hit_valid,
    input  logic                 hit_ready,
    output fips_pkg::hit_t       hit
);
    logic [2:0]  mode_reg;
    logic [1:0]  pad_pol_reg;
    logic        acc_fix_reg;
    logic [19:0] thr_reg;

    logic signed [fips_pkg::SUM_W-1:0] sx_reg, sy_reg, sz_reg;
    logic signed [fips_pkg::SUM_W-1:0] sx_next, sy_next, sz_next;
    logic [fips_pkg::WSUM_W-1:0]       sw_reg, sw_next;
    logic [20:0]                       bm_reg, bm_next;
    logic signed [15:0]                bx_reg, by_reg, bz_reg, bx_next, by_next, bz_next;
    logic                              fix_reg, fix_next;
    logic [fips_pkg::SEEN_W-1:0]       seen_reg, seen_next;

    logic                              out_v_reg;
    fips_pkg::hit_t                    out_reg, res;

    logic signed [15:0] x, y, z;
    logic signed [20:0] e;
    logic               fixp, hy_best, take, pv;
    logic [20:0]        metric;
    logic signed [36:0] mx, my, mz;

    assign in_ready  = !out_v_reg || hit_ready;
    assign hit_valid = out_v_reg;
    assign hit       = out_reg;

    always_comb begin
        fixp    = fix_reg || t0nan || (pe <= 21'sd0);
        x       = fixp ? 16'sd0 : px;
        y       = fixp ? 16'sd0 : py;
        z       = fixp ? 16'sd0 : pz;
        e       = fixp ? 21'sd1 : pe;
        hy_best = hit_e > thr_reg;
        mx      = x * e;
        my      = y * e;
        mz      = z * e;
        metric  = (mode_reg == fips_pkg::MODE_MIN_Z) ?
                  21'(32'sd32768 - 32'(z)) : e[20:0];
        take    = metric > bm_reg;

        sx_next = sx_reg; sy_next = sy_reg; sz_next = sz_reg; sw_next = sw_reg;
        bm_next = bm_reg; bx_next = bx_reg; by_next = by_reg; bz_next = bz_reg;
        fix_next = fix_reg; seen_next = seen_reg;
        if (seen_reg < fips_pkg::SEEN_W'(fips_pkg::MAX_POINTS)) begin
            seen_next = seen_reg + 1'b1;
            fix_next  = fixp;
            if (mode_reg == fips_pkg::MODE_MEAN) begin
                sx_next = sx_reg + fips_pkg::SUM_W'(x);
                sy_next = sy_reg + fips_pkg::SUM_W'(y);
                sz_next = sz_reg + fips_pkg::SUM_W'(z);
            end else if (mode_reg == fips_pkg::MODE_WEIGHT ||
                         (mode_reg == fips_pkg::MODE_HYBRID && !hy_best)) begin
                sx_next = sx_reg + fips_pkg::SUM_W'(mx);
                sy_next = sy_reg + fips_pkg::SUM_W'(my);
                sz_next = sz_reg + fips_pkg::SUM_W'(mz);
                sw_next = sw_reg + fips_pkg::WSUM_W'(e);
            end else if (take && (mode_reg == fips_pkg::MODE_MIN_Z ||
                         mode_reg == fips_pkg::MODE_MAX_E ||
                         mode_reg == fips_pkg::MODE_HYBRID)) begin
                bm_next = metric;
                bx_next = x; by_next = y; bz_next = z;
            end
        end

        unique case (pad_pol_reg)
            fips_pkg::PAD_EITHER: pv = (pad == fips_pkg::PAD_OK) || (pad == fips_pkg::PAD_RETRY);
            fips_pkg::PAD_NOISY:  pv = (pad == fips_pkg::PAD_OK) ||
                                       ((pad == fips_pkg::PAD_RETRY) && noisy);
            default:              pv = (pad == fips_pkg::PAD_OK);
        endcase

        res        = '0;
        res.sx     = sx_next; res.sy = sy_next; res.sz = sz_next;
        res.bx     = bx_next; res.by = by_next; res.bz = bz_next;
        res.fix    = fix_next;
        res.valid  = pv && !(fix_next && !acc_fix_reg);
        unique case (mode_reg)
            fips_pkg::MODE_MIN_Z, fips_pkg::MODE_MAX_E: res.divide = 1'b0;
            fips_pkg::MODE_MEAN: begin
                res.divide = 1'b1;
                res.den    = fips_pkg::WSUM_W'(count);
            end
            fips_pkg::MODE_WEIGHT, fips_pkg::MODE_HYBRID: begin
                if (mode_reg == fips_pkg::MODE_HYBRID && hy_best) begin
                    res.divide = 1'b0;
                end else begin
                    res.divide = 1'b1;
                    res.den    = (sw_next[fips_pkg::WSUM_W-1]) ? '0 : sw_next;
                end
            end
            default: begin
                // centre and unused codes: origin
                res.divide = 1'b0;
                res.bx = '0; res.by = '0; res.bz = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= fips_pkg::MODE_WEIGHT; pad_pol_reg <= fips_pkg::PAD_STRICT;
            acc_fix_reg <= 1'b0; thr_reg <= 20'd515;
            sx_reg <= '0; sy_reg <= '0; sz_reg <= '0; sw_reg <= '0; bm_reg <= '0;
            bx_reg <= '0; by_reg <= '0; bz_reg <= '0; fix_reg <= 1'b0; seen_reg <= '0;
            out_v_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    fips_pkg::REG_SELECT_MODE: mode_reg    <= cfg_data[2:0];
                    fips_pkg::REG_PAD_POLICY:  pad_pol_reg <= cfg_data[1:0];
                    fips_pkg::REG_ACCEPT_FIX:  acc_fix_reg <= cfg_data[0];
                    default:                   thr_reg     <= cfg_data;
                endcase
            end
            if (in_valid && in_ready && last) out_v_reg <= 1'b1;
            else if (hit_ready)               out_v_reg <= 1'b0;
            if (in_valid && in_ready) begin
                if (last) begin
                    out_reg   <= res;
                    sx_reg <= '0; sy_reg <= '0; sz_reg <= '0; sw_reg <= '0; bm_reg <= '0;
                    bx_reg <= '0; by_reg <= '0; bz_reg <= '0; fix_reg <= 1'b0;
                    seen_reg <= '0;
                end else begin
                    sx_reg <= sx_next; sy_reg <= sy_next; sz_reg <= sz_next;
                    sw_reg <= sw_next; bm_reg <= bm_next;
                    bx_reg <= bx_next; by_reg <= by_next; bz_reg <= bz_next;
                    fix_reg <= fix_next; seen_reg <= seen_next;
                end
            end
        end
    end
endmodule

[rtl/fips_queue.sv]
// Short FIFO of finished hits between front and back end.
// Depends on fips_pkg for hit_t and the queue depth.
module fips_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  fips_pkg::hit_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output fips_pkg::hit_t rd_data
);
    localparam int AW = $clog2(fips_pkg::Q_DEPTH);
    fips_pkg::hit_t        mem [fips_pkg::Q_DEPTH];
    logic [AW-1:0]         wp_reg, rp_reg;
    logic [AW:0]           cnt_reg;
    logic                  wr, rd;

    assign wr_ready = cnt_reg != (AW+1)'(fips_pkg::Q_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr) mem[wp_reg] <= wr_data;
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule

[rtl/fips_back.sv]
// Back end: divides the three sums by the weight or count, one quotient bit
// per cycle, saturates and holds the result beat. Depends on fips_pkg.
module fips_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  fips_pkg::hit_t q_data,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [47:0]    m_xyz,
    output logic           m_ok,
    output logic           m_fix
);
    localparam int SW = fips_pkg::SUM_W;
    localparam int CW = $clog2(SW);
    typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_t;

    state_t                state_reg;
    logic [1:0]            axis_reg;
    logic [CW-1:0]         bit_reg;
    logic [SW-1:0]         num_reg, quo_reg;
    logic [SW:0]           rem_reg;
    logic                  neg_reg;
    fips_pkg::hit_t        h_reg;
    logic [15:0]           r_reg [3];
    logic [SW:0]           rem_sh;
    logic                  ge;
    logic signed [SW-1:0]  qs;
    logic [15:0]           sat;

    assign q_ready = state_reg == S_IDLE;
    assign m_valid = state_reg == S_OUT;
    assign m_xyz   = {r_reg[2], r_reg[1], r_reg[0]};
    assign m_ok    = h_reg.valid;
    assign m_fix   = h_reg.fix;

    always_comb begin
        rem_sh = {rem_reg[SW-1:0], num_reg[SW-1]};
        ge     = rem_sh >= (SW+1)'(h_reg.den);
        qs = neg_reg ? -$signed({quo_reg[SW-2:0], ge}) : $signed({quo_reg[SW-2:0], ge});
        if (qs > 42'sd32767)       sat = 16'h7fff;
        else if (qs < -42'sd32768) sat = 16'h8000;
        else                       sat = qs[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: if (q_valid) begin
                    h_reg <= q_data;
                    if (q_data.divide && q_data.den != '0) begin
                        axis_reg  <= 2'd0;
                        bit_reg   <= CW'(SW-1);
                        neg_reg   <= q_data.sx[SW-1];
                        num_reg   <= q_data.sx[SW-1] ? SW'(-q_data.sx) : q_data.sx;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        state_reg <= S_DIV;
                    end else begin
                        r_reg[0]  <= q_data.divide ? 16'd0 : q_data.bx;
                        r_reg[1]  <= q_data.divide ? 16'd0 : q_data.by;
                        r_reg[2]  <= q_data.divide ? 16'd0 : q_data.bz;
                        state_reg <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (bit_reg == '0) begin
                        r_reg[axis_reg] <= sat;
                        if (axis_reg == 2'd2) begin
                            state_reg <= S_OUT;
                        end else begin
                            // load next axis
                            axis_reg <= axis_reg + 1'b1;
                            bit_reg  <= CW'(SW-1);
                            rem_reg  <= '0;
                            quo_reg  <= '0;
                            if (axis_reg == 2'd0) begin
                                neg_reg <= h_reg.sy[SW-1];
                                num_reg <= h_reg.sy[SW-1] ? SW'(-h_reg.sy) : h_reg.sy;
                            end else begin
                                neg_reg <= h_reg.sz[SW-1];
                                num_reg <= h_reg.sz[SW-1] ? SW'(-h_reg.sz) : h_reg.sz;
                            end
                        end
                    end else begin
                        rem_reg <= ge ? rem_sh - (SW+1)'(h_reg.den) : rem_sh;
                        num_reg <= {num_reg[SW-2:0], 1'b0};
                        quo_reg <= {quo_reg[SW-2:0], ge};
                        bit_reg <= bit_reg - 1'b1;
                    end
                end
                S_OUT: if (m_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

[tb/tb.sv]
// Testbench for first_interaction_point_select_top: drives hits as point beats,
// predicts each hit's result in-house and checks the result stream field by field.
// Depends on fips_pkg and the top-level RTL only.
module tb;

    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;
    localparam logic [1:0] PAD_SPARE   = 2'd3;
    localparam int DRAIN_CYCLES = 160;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_ITEMS = 1800;

    typedef struct {
        logic signed [15:0] x, y, z;
        logic signed [20:0] e;
        logic [19:0] hit_e;
        logic [7:0]  pad;
        logic        noisy, nan;
        logic [4:0]  count;
        logic        last;
    } point_t;

    typedef struct {
        logic signed [15:0] x, y, z;
        logic               valid, fix;
    } hit_res_t;

    typedef struct {
        logic [2:0]  mode;
        logic [1:0]  pad_pol;
        logic        acc;
        logic [19:0] thr;
        point_t      pt;
        logic        typed;
        hit_res_t    res;
    } dir_row_t;

    logic         aclk, aresetn;
    logic         cfg_wr_en;
    logic [1:0]   cfg_index;
    logic [19:0]  cfg_data;
    logic         s_tvalid, s_tready, s_tlast;
    logic [103:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid, m_tready;
    logic [47:0]  m_tdata;
    logic [1:0]   m_tuser;

    first_interaction_point_select_top u_dut (.*);

    // register shadow
    logic [2:0]  cur_mode;
    logic [1:0]  cur_pad;
    logic        cur_acc;
    logic [19:0] cur_thr;

    // hit accumulator shadow
    longint  acc_sx, acc_sy, acc_sz, acc_sw, acc_best;
    longint  best_x, best_y, best_z;
    bit      hit_fix;
    int      hit_seen;

    hit_res_t result_q[$];
    int  mismatches;
    int  cycles;
    int  burst_left;
    bit  no_gaps;
    dir_row_t rows[$];

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("first_interaction_point_select_top test failed");
            $finish;
        end
    end

    // receiver: the stall style rotates through four patterns as the cycle counter runs
    always @(negedge aclk) begin
        case ((cycles / 256) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (cycles % 23) < 5;
            default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic void clear_hit();
        acc_sx = 0; acc_sy = 0; acc_sz = 0; acc_sw = 0; acc_best = 0;
        best_x = 0; best_y = 0; best_z = 0;
        hit_fix = 0; hit_seen = 0;
    endfunction

    function automatic void keep_best(longint m, longint x, longint y, longint z);
        if (m > acc_best) begin
            acc_best = m; best_x = x; best_y = y; best_z = z;
        end
    endfunction

    function automatic void add_weighted(longint x, longint y, longint z, longint e);
        acc_sx += x * e; acc_sy += y * e; acc_sz += z * e; acc_sw += e;
    endfunction

    // fold one accepted point into the hit; returns 1 with a result on the last point
    function automatic bit fold_point(point_t p, output hit_res_t r);
        longint x, y, z, e, rx, ry, rz;
        bit ok;
        x = longint'(p.x); y = longint'(p.y); z = longint'(p.z); e = longint'(p.e);
        rx = 0; ry = 0; rz = 0;
        if (hit_seen < fips_pkg::MAX_POINTS) begin
            hit_seen++;
            if (p.nan) hit_fix = 1;
            if (hit_fix || e <= 0) begin
                x = 0; y = 0; z = 0; e = 1; hit_fix = 1;
            end
            case (cur_mode)
                fips_pkg::MODE_MIN_Z:  keep_best(32768 - z, x, y, z);
                fips_pkg::MODE_MEAN:   begin acc_sx += x; acc_sy += y; acc_sz += z; end
                fips_pkg::MODE_WEIGHT: add_weighted(x, y, z, e);
                fips_pkg::MODE_MAX_E:  keep_best(e, x, y, z);
                fips_pkg::MODE_HYBRID: begin
                    if (p.hit_e > cur_thr) keep_best(e, x, y, z);
                    else add_weighted(x, y, z, e);
                end
                default: ;
            endcase
        end
        if (!p.last) return 0;
        case (cur_mode)
            fips_pkg::MODE_MIN_Z, fips_pkg::MODE_MAX_E: begin
                rx = best_x; ry = best_y; rz = best_z;
            end
            fips_pkg::MODE_MEAN: begin
                if (p.count != 0) begin
                    rx = acc_sx / longint'(p.count);
                    ry = acc_sy / longint'(p.count);
                    rz = acc_sz / longint'(p.count);
                end
            end
            fips_pkg::MODE_WEIGHT, fips_pkg::MODE_HYBRID: begin
                if (cur_mode == fips_pkg::MODE_HYBRID && p.hit_e > cur_thr) begin
                    rx = best_x; ry = best_y; rz = best_z;
                end else if (acc_sw > 0) begin
                    rx = acc_sx / acc_sw; ry = acc_sy / acc_sw; rz = acc_sz / acc_sw;
                end
            end
            default: ;
        endcase
        if (cur_pad == fips_pkg::PAD_EITHER)
            ok = (p.pad == fips_pkg::PAD_OK || p.pad == fips_pkg::PAD_RETRY);
        else if (cur_pad == fips_pkg::PAD_NOISY)
            ok = (p.pad == fips_pkg::PAD_OK) || (p.pad == fips_pkg::PAD_RETRY && p.noisy);
        else ok = (p.pad == fips_pkg::PAD_OK);
        if (!cur_acc && hit_fix) ok = 0;
        r.x = clamp16(rx); r.y = clamp16(ry); r.z = clamp16(rz);
        r.valid = ok; r.fix = hit_fix;
        clear_hit();
        return 1;
    endfunction

    always @(posedge aclk) begin
        hit_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h/%h", m_tdata, m_tuser);
            end else begin
                want = result_q.pop_front();
                if (m_tdata[15:0] !== want.x || m_tdata[31:16] !== want.y ||
                    m_tdata[47:32] !== want.z || m_tuser[0] !== want.valid ||
                    m_tuser[1] !== want.fix) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%0d y=%0d z=%0d v=%b f=%b, got x=%0d y=%0d z=%0d v=%b f=%b",
                                 want.x, want.y, want.z, want.valid, want.fix,
                                 $signed(m_tdata[15:0]), $signed(m_tdata[31:16]),
                                 $signed(m_tdata[47:32]), m_tuser[0], m_tuser[1]);
                end
            end
        end
    end

    task automatic wait_idle();
        wait (result_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [19:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1; cfg_index = idx; cfg_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic apply_setting(logic [2:0] m, logic [1:0] pp, logic a, logic [19:0] t,
                                 bit all_regs);
        if (!all_regs && m == cur_mode && pp == cur_pad && a == cur_acc && t == cur_thr)
            return;
        wait_idle();
        if (all_regs || m != cur_mode) write_reg(fips_pkg::REG_SELECT_MODE, 20'(m));
        if (all_regs || pp != cur_pad) write_reg(fips_pkg::REG_PAD_POLICY, 20'(pp));
        if (all_regs || a != cur_acc) write_reg(fips_pkg::REG_ACCEPT_FIX, 20'(a));
        if (all_regs || t != cur_thr) write_reg(fips_pkg::REG_HYBRID_THR, t);
        cur_mode = m; cur_pad = pp; cur_acc = a; cur_thr = t;
    endtask

    // drive one point beat, with bursts and gaps; expectation comes from the predictor
    // unless a typed one is given
    task automatic send_point(point_t p, bit typed, hit_res_t typed_res);
        hit_res_t r;
        if (!no_gaps && burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        s_tdata  = {2'b00, p.count, p.pad, p.hit_e, p.e, p.z, p.y, p.x};
        s_tuser  = {p.nan, p.noisy};
        s_tlast  = p.last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (fold_point(p, r)) result_q.push_back(typed ? typed_res : r);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    function automatic point_t mk_pt(int x, int y, int z, int e, int he, int pad,
                                     bit noisy, bit nan, int cnt, bit last);
        point_t p;
        p.x = 16'(x); p.y = 16'(y); p.z = 16'(z); p.e = 21'(e);
        p.hit_e = 20'(he); p.pad = 8'(pad);
        p.noisy = noisy; p.nan = nan; p.count = 5'(cnt); p.last = last;
        return p;
    endfunction

    function automatic void add_row(logic [2:0] m, logic [1:0] pp, logic a, logic [19:0] t,
                                    point_t p, bit typed, int ex, int ey, int ez,
                                    bit ev, bit ef);
        dir_row_t d;
        d.mode = m; d.pad_pol = pp; d.acc = a; d.thr = t; d.pt = p; d.typed = typed;
        d.res.x = 16'(ex); d.res.y = 16'(ey); d.res.z = 16'(ez);
        d.res.valid = ev; d.res.fix = ef;
        rows.push_back(d);
    endfunction

    initial begin
        point_t p;
        hit_res_t none;
        int sent, n, phase;
        logic [19:0] he;
        logic [7:0] pad;
        logic noisy;

        aresetn = 1'b0; cfg_wr_en = 1'b0; cfg_index = '0; cfg_data = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; s_tlast = 1'b0;
        m_tready = 1'b1; mismatches = 0; cycles = 0; burst_left = 0; no_gaps = 0;
        none = '{default: '0};
        cur_mode = fips_pkg::MODE_WEIGHT; cur_pad = fips_pkg::PAD_STRICT;
        cur_acc = 1'b0; cur_thr = 20'd515;
        clear_hit();
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // reset settings, weighted mean
        add_row(fips_pkg::MODE_WEIGHT, fips_pkg::PAD_STRICT, 0, 515,
                mk_pt(100, 200, 300, 5, 9, 0, 0, 0, 1, 1),
                1, 100, 200, 300, 1, 0);
        add_row(fips_pkg::MODE_WEIGHT, fips_pkg::PAD_STRICT, 0, 515,
                mk_pt(32767, -32768, 32767, 1048575, 1048575, 0, 1, 0, 31, 1),
                1, 32767, -32768, 32767, 1, 0);
        add_row(fips_pkg::MODE_WEIGHT, fips_pkg::PAD_STRICT, 0, 515,
                mk_pt(-32768, 5, 5, 0, 0, 0, 0, 0, 1, 1),
                1, 0, 0, 0, 0, 1);
        add_row(fips_pkg::MODE_WEIGHT, fips_pkg::PAD_STRICT, 0, 515,
                mk_pt(7, 7, 7, 7, 0, 0, 0, 1, 1, 1),
                1, 0, 0, 0, 0, 1);
        add_row(fips_pkg::MODE_WEIGHT, fips_pkg::PAD_STRICT, 0, 515,
                mk_pt(1, 1, 1, 3, 0, 128, 1, 0, 1, 1),
                1, 1, 1, 1, 0, 0);
        // a negative energy mid-hit keeps the fix for the rest of the hit
        add_row(fips_pkg::MODE_WEIGHT, fips_pkg::PAD_STRICT, 1, 515,
                mk_pt(10, -4, 3, 5, 0, 0, 0, 0, 3, 0),
                0, 0, 0, 0, 0, 0);
        add_row(fips_pkg::MODE_WEIGHT, fips_pkg::PAD_STRICT, 1, 515,
                mk_pt(9, 9, 9, -1048576, 0, 0, 0, 0, 3, 0),
                0, 0, 0, 0, 0, 0);
        add_row(fips_pkg::MODE_WEIGHT, fips_pkg::PAD_STRICT, 1, 515,
                mk_pt(20, 8, -6, 9, 0, 0, 0, 0, 3, 1),
                0, 0, 0, 0, 0, 0);
        // smallest z
        add_row(fips_pkg::MODE_MIN_Z, fips_pkg::PAD_EITHER, 1, 515,
                mk_pt(1, 2, 5, 4, 0, 128, 0, 0, 2, 0),
                0, 0, 0, 0, 0, 0);
        add_row(fips_pkg::MODE_MIN_Z, fips_pkg::PAD_EITHER, 1, 515,
                mk_pt(3, 4, -3, 4, 0, 128, 0, 0, 2, 1),
                0, 0, 0, 0, 0, 0);
        // mean, zero count then a real one
        add_row(fips_pkg::MODE_MEAN, fips_pkg::PAD_NOISY, 0, 515,
                mk_pt(50, 50, 50, 2, 0, 128, 1, 0, 0, 1),
                1, 0, 0, 0, 1, 0);
        add_row(fips_pkg::MODE_MEAN, fips_pkg::PAD_NOISY, 0, 515,
                mk_pt(-7, 3, 1, 2, 0, 128, 0, 0, 2, 0),
                0, 0, 0, 0, 0, 0);
        add_row(fips_pkg::MODE_MEAN, fips_pkg::PAD_NOISY, 0, 515,
                mk_pt(0, 4, 2, 2, 0, 128, 0, 0, 2, 1),
                0, 0, 0, 0, 0, 0);
        add_row(fips_pkg::MODE_CENTRE, PAD_SPARE, 0, 515,
                mk_pt(9, 9, 9, 9, 0, 128, 1, 0, 1, 1),
                1, 0, 0, 0, 0, 0);
        // largest energy
        add_row(fips_pkg::MODE_MAX_E, fips_pkg::PAD_STRICT, 0, 515,
                mk_pt(1, 1, 1, 10, 0, 0, 0, 0, 2, 0),
                0, 0, 0, 0, 0, 0);
        add_row(fips_pkg::MODE_MAX_E, fips_pkg::PAD_STRICT, 0, 515,
                mk_pt(2, 2, 2, 30, 0, 0, 0, 0, 2, 1),
                0, 0, 0, 0, 0, 0);
        // hybrid above and at the threshold
        add_row(fips_pkg::MODE_HYBRID, fips_pkg::PAD_STRICT, 0, 515,
                mk_pt(4, 5, 6, 3, 1000, 0, 0, 0, 2, 0),
                0, 0, 0, 0, 0, 0);
        add_row(fips_pkg::MODE_HYBRID, fips_pkg::PAD_STRICT, 0, 515,
                mk_pt(7, 8, 9, 2, 1000, 0, 0, 0, 2, 1),
                0, 0, 0, 0, 0, 0);
        add_row(fips_pkg::MODE_HYBRID, fips_pkg::PAD_STRICT, 0, 515,
                mk_pt(4, 5, 6, 3, 515, 0, 0, 0, 2, 0),
                0, 0, 0, 0, 0, 0);
        add_row(fips_pkg::MODE_HYBRID, fips_pkg::PAD_STRICT, 0, 515,
                mk_pt(8, 9, 10, 1, 515, 0, 0, 0, 2, 1),
                0, 0, 0, 0, 0, 0);
        add_row(MODE_SPARE6, fips_pkg::PAD_STRICT, 0, 515,
                mk_pt(5, 5, 5, 5, 0, 0, 0, 0, 1, 1),
                1, 0, 0, 0, 1, 0);
        add_row(MODE_SPARE7, fips_pkg::PAD_STRICT, 0, 515,
                mk_pt(5, 5, 5, 5, 0, 0, 0, 0, 1, 1),
                1, 0, 0, 0, 1, 0);

        foreach (rows[i]) begin
            apply_setting(rows[i].mode, rows[i].pad_pol, rows[i].acc, rows[i].thr, 0);
            send_point(rows[i].pt, rows[i].typed, rows[i].res);
        end
        // more points than the hit can hold, in largest energy mode
        apply_setting(fips_pkg::MODE_MAX_E, fips_pkg::PAD_STRICT, 0, 515, 0);
        for (int k = 0; k < fips_pkg::MAX_POINTS + 3; k++)
            send_point(mk_pt(k, -k, k, (k == fips_pkg::MAX_POINTS + 1) ? 1000 : k + 1,
                             0, 0, 0, 0, 16, k == fips_pkg::MAX_POINTS + 2), 0, none);

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            logic [19:0] thr;
            case (phase % 4)
                0: thr = 20'd0;
                1: thr = 20'hFFFFF;
                2: thr = 20'd515;
                default: thr = 20'($urandom);
            endcase
            apply_setting(3'(phase % 8), 2'(phase % 4), 1'($urandom_range(0, 1)), thr, 1);
            no_gaps = (phase % 3 == 0);
            for (int items = 0; items < 150 && sent < RANDOM_ITEMS; ) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20)
                                                : $urandom_range(1, fips_pkg::MAX_POINTS);
                he = ($urandom_range(0, 1)) ? 20'($urandom)
                                            : 20'(thr + $urandom_range(0, 2) - 1);
                pad = ($urandom_range(0, 2) == 0) ? 8'($urandom) :
                      ($urandom_range(0, 1) ? fips_pkg::PAD_OK : fips_pkg::PAD_RETRY);
                noisy = 1'($urandom_range(0, 1));
                for (int k = 0; k < n; k++) begin
                    p.x = 16'($urandom); p.y = 16'($urandom); p.z = 16'($urandom);
                    case ($urandom_range(0, 9))
                        0: p.e = 21'($urandom);
                        1: p.e = -$signed(21'($urandom_range(0, 100)));
                        2, 3: p.e = 21'($urandom_range(1, 20));
                        default: p.e = 21'($urandom_range(1, 1048575));
                    endcase
                    p.hit_e = ($urandom_range(0, 19) == 0) ? 20'($urandom) : he;
                    p.pad = pad; p.noisy = noisy;
                    p.nan = ($urandom_range(0, 29) == 0);
                    p.count = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'(n);
                    p.last = (k == n - 1);
                    send_point(p, 0, none);
                    sent++; items++;
                end
            end
            phase++;
        end

        wait_idle();
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("first_interaction_point_select_top test passed");
        end else begin
            $display("first_interaction_point_select_top test failed");
        end
        $finish;
    end
endmodule
